[src/contiguous_slot_allocator_defines.svh]
// Assertion macros for the port-level checker of the slot allocator.
`ifndef CONTIGUOUS_SLOT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSA_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("slot allocator check failed");

// Next-cycle implication, checked outside reset.
`define CSA_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("slot allocator check failed");

`endif

[src/csa_pkg.sv]
// ----------------------------------------------------------------------------
// csa_pkg
// Sizes, status codes and opcodes of the contiguous slot allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csa_pkg;

    localparam int SLOT_W      = 8;
    localparam int TABLE_SLOTS = 1 << SLOT_W;
    localparam int IDX_W       = SLOT_W + 1;
    localparam int EXT_W       = IDX_W + 1;
    localparam int OWNER_W     = 16;

    localparam logic [IDX_W-1:0] NONE_SLOT = IDX_W'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

    localparam logic [1:0] STAT_FAIL    = 2'd0;
    localparam logic [1:0] STAT_DONE    = 2'd1;
    localparam logic [1:0] STAT_PARTIAL = 2'd2;
    localparam logic [1:0] STAT_PLACED  = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Any index past the table end collapses to the none marker.
    function automatic logic [IDX_W-1:0] clamp_slot(input logic [EXT_W-1:0] x);
        logic [IDX_W-1:0] r;
        if (x >= EXT_W'(TABLE_SLOTS)) begin
            r = NONE_SLOT;
        end else begin
            r = x[IDX_W-1:0];
        end
        return r;
    endfunction

endpackage

[src/csa_ram.sv]
// ----------------------------------------------------------------------------
// csa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csa_ram #(
    parameter int WIDTH = 9,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [(1 << AW)];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/contiguous_slot_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_slot_allocator
// Slot table with first-fit insert and merging remove, run by a sequencer.
// ----------------------------------------------------------------------------
// Usage: one input word on the s_ channel is either an insert of a library
// page or a remove of a block; each gives exactly one result word on m_.
// The block takes one word at a time: s_ready is high only while idle.
// Work varies with the operation: a check that fails early shows its result
// in the cycle in which the block is also ready again. An insert walk visits
// the free runs in turn and then reads the end of the fitting run, a remove
// walk follows the free links one by one, and placing, freeing or relinking
// writes the slots one by one.
// The finished result sits in an output register; a new word is accepted
// while it waits, and its own result waits until m_ready takes the old one.
// Reset empties the table at once: free bits reset to ones and a link valid
// bit per slot makes unwritten links read as their reset value, so there is
// no clearing pass. table_id resets to 65535; the user must write it through
// cfg_wr_en/cfg_wr_data only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module contiguous_slot_allocator
    import csa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [15:0]        s_lib_id,
    input  logic [15:0]        s_got_entries,
    input  logic [7:0]         s_table_number,
    input  logic [8:0]         s_recorded_first,
    input  logic [15:0]        s_lib_last_table,
    input  logic [7:0]         s_first_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic               m_set_record,
    output logic [8:0]         m_start_index,
    output logic [15:0]        m_owner_lib,
    output logic               m_clear_record
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_I_EMPTY, S_W_CHECK, S_W_LINK, S_W_NEXT, S_W_E,
        S_W_DONE, S_PLACE, S_RELINK, S_R_OWN, S_R_END2, S_R_END3, S_R_FREE,
        S_R_WALK, S_R_WNEXT, S_R_TAIL, S_R_RELINK, S_OUT
    } state_t;

    localparam logic [EXT_W-1:0] SLOTS_X = EXT_W'(TABLE_SLOTS);

    state_t state_reg, state_next;

    // Table state. Free bits and link valid bits are flip-flops.
    logic [TABLE_SLOTS-1:0] free_reg;
    logic [TABLE_SLOTS-1:0] lvalid_reg;
    logic [IDX_W-1:0]       ffs_reg, ffs_next;
    logic [15:0]            table_id_reg;

    // Captured input word.
    logic        op_reg;
    logic [15:0] lib_reg, cnt_reg, last_tab_reg;
    logic [7:0]  tn_reg, fi_reg;
    logic [8:0]  rec_reg;

    // Walk registers.
    logic [EXT_W-1:0] cur_reg, cur_next;
    logic [EXT_W-1:0] nxt_reg, nxt_next;
    logic [EXT_W-1:0] prv_reg, prv_next;
    logic [EXT_W-1:0] idx_reg, idx_next;
    logic [EXT_W-1:0] end_reg, end_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] guard_reg, guard_next;
    logic [1:0]       stat_reg, stat_next;
    logic             setr_reg, setr_next;
    logic [EXT_W-1:0] rd_idx_reg, rd_idx_next;

    // Pending result.
    logic [1:0]       res_stat_reg, res_stat_next;
    logic             res_setr_reg, res_setr_next;
    logic [IDX_W-1:0] res_start_reg, res_start_next;
    logic [15:0]      res_owner_reg, res_owner_next;
    logic             res_clr_reg, res_clr_next;

    // Output register.
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic             m_set_record_reg;
    logic [IDX_W-1:0] m_start_index_reg;
    logic [15:0]      m_owner_lib_reg;
    logic             m_clear_record_reg;

    // RAM ports and free-bit strobes.
    logic              link_we;
    logic [SLOT_W-1:0] link_waddr;
    logic [IDX_W-1:0]  link_wdata;
    logic [IDX_W-1:0]  link_rdata;
    logic              own_we;
    logic [15:0]       own_rdata;
    logic              free_we;
    logic              free_wval;
    logic [SLOT_W-1:0] free_widx;
    logic [IDX_W-1:0]  link_val;
    logic              out_free;

    function automatic logic free_at(input logic [TABLE_SLOTS-1:0] f,
                                     input logic [EXT_W-1:0] x);
        logic r;
        r = (x < SLOTS_X) && f[x[SLOT_W-1:0]];
        return r;
    endfunction

    csa_ram #(.WIDTH(IDX_W), .AW(SLOT_W)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_idx_next[SLOT_W-1:0]),
        .rdata (link_rdata)
    );

    csa_ram #(.WIDTH(OWNER_W), .AW(SLOT_W)) u_owner_ram (
        .aclk  (aclk),
        .we    (own_we),
        .waddr (idx_reg[SLOT_W-1:0]),
        .wdata (lib_reg),
        .raddr (fi_reg),
        .rdata (own_rdata)
    );

    // Link of the slot read in the previous cycle, with reset values for
    // slots never written and none for anything past the table end.
    always_comb begin
        if (rd_idx_reg >= SLOTS_X) begin
            link_val = NONE_SLOT;
        end else if (lvalid_reg[rd_idx_reg[SLOT_W-1:0]]) begin
            link_val = link_rdata;
        end else if (rd_idx_reg[IDX_W-1:0] == LAST_SLOT) begin
            link_val = NONE_SLOT;
        end else begin
            link_val = LAST_SLOT;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        logic [EXT_W-1:0] lk;
        logic [EXT_W-1:0] sp1;
        logic [EXT_W-1:0] lim;
        logic [EXT_W-1:0] e;
        logic [15:0]      cnt1;
        logic             fit;
        state_next     = state_reg;
        ffs_next       = ffs_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        prv_next       = prv_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        n_next         = n_reg;
        guard_next     = guard_reg;
        stat_next      = stat_reg;
        setr_next      = setr_reg;
        rd_idx_next    = rd_idx_reg;
        res_stat_next  = res_stat_reg;
        res_setr_next  = res_setr_reg;
        res_start_next = res_start_reg;
        res_owner_next = res_owner_reg;
        res_clr_next   = res_clr_reg;
        link_we        = 1'b0;
        link_waddr     = idx_reg[SLOT_W-1:0];
        link_wdata     = NONE_SLOT;
        own_we         = 1'b0;
        free_we        = 1'b0;
        free_wval      = 1'b0;
        free_widx      = idx_reg[SLOT_W-1:0];
        lk             = {1'b0, link_val};
        sp1            = lk + EXT_W'(1);
        lim            = cur_reg + {1'b0, n_reg};
        e              = lim - EXT_W'(1);
        cnt1           = (cnt_reg == 16'd0) ? 16'd1 : cnt_reg;
        fit            = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                res_owner_next = 16'd0;
                res_clr_next   = 1'b0;
                res_setr_next  = 1'b0;
                res_start_next = NONE_SLOT;
                res_stat_next  = STAT_FAIL;
                if (op_reg == OP_INSERT) begin
                    prv_next   = {1'b0, NONE_SLOT};
                    nxt_next   = '0;
                    guard_next = '0;
                    n_next     = (cnt1[SLOT_W-1:0] == '0) ? IDX_W'(TABLE_SLOTS)
                                                          : {1'b0, cnt1[SLOT_W-1:0]};
                    if (rec_reg != NONE_SLOT) begin
                        res_stat_next = STAT_PLACED;
                        state_next    = S_OUT;
                    end else if (16'(tn_reg) < ((cnt1 - 16'd1) >> SLOT_W)) begin
                        // Non-final page: needs an empty table.
                        rd_idx_next = '0;
                        state_next  = S_I_EMPTY;
                    end else begin
                        setr_next  = 1'b1;
                        stat_next  = STAT_DONE;
                        cur_next   = {1'b0, ffs_reg};
                        state_next = S_W_CHECK;
                    end
                end else begin
                    if (free_reg[fi_reg]) begin
                        state_next = S_OUT;
                    end else begin
                        if (table_id_reg == last_tab_reg
                            && cnt_reg[SLOT_W-1:0] != '0) begin
                            n_next = {1'b0, cnt_reg[SLOT_W-1:0]};
                        end else begin
                            n_next = IDX_W'(TABLE_SLOTS);
                        end
                        state_next = S_R_OWN;
                    end
                end
            end
            S_I_EMPTY: begin
                if (ffs_reg == '0 && link_val == LAST_SLOT && free_reg[1]) begin
                    cur_next   = '0;
                    nxt_next   = {1'b0, NONE_SLOT};
                    n_next     = IDX_W'(TABLE_SLOTS);
                    setr_next  = 1'b0;
                    stat_next  = STAT_PARTIAL;
                    idx_next   = '0;
                    state_next = S_PLACE;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_W_CHECK: begin
                if (!free_at(free_reg, cur_reg)) begin
                    state_next = S_W_DONE;
                end else if (guard_reg >= IDX_W'(TABLE_SLOTS)) begin
                    cur_next   = {1'b0, NONE_SLOT};
                    state_next = S_W_DONE;
                end else begin
                    guard_next  = guard_reg + IDX_W'(1);
                    rd_idx_next = cur_reg;
                    state_next  = S_W_LINK;
                end
            end
            S_W_LINK: begin
                // Fit test keeps the wrap of the unsigned difference.
                if (link_val == NONE_SLOT) begin
                    fit = (n_reg == IDX_W'(1)) && (cur_reg != '0);
                end else begin
                    fit = (sp1 < cur_reg) || ((sp1 - cur_reg) >= {1'b0, n_reg});
                end
                if (fit) begin
                    rd_idx_next = e;
                    state_next  = S_W_E;
                end else if (link_val != NONE_SLOT) begin
                    prv_next    = lk;
                    rd_idx_next = lk;
                    state_next  = S_W_NEXT;
                end else begin
                    cur_next   = {1'b0, NONE_SLOT};
                    state_next = S_W_DONE;
                end
            end
            S_W_NEXT: begin
                cur_next   = lk;
                state_next = S_W_CHECK;
            end
            S_W_E: begin
                if (link_val == NONE_SLOT || !free_at(free_reg, lim)) begin
                    nxt_next = lk;
                end else begin
                    nxt_next = lim;
                end
                state_next = S_W_DONE;
            end
            S_W_DONE: begin
                if (cur_reg >= SLOTS_X) begin
                    res_setr_next = setr_reg;
                    state_next    = S_OUT;
                end else begin
                    idx_next   = cur_reg;
                    state_next = S_PLACE;
                end
            end
            S_PLACE: begin
                if (idx_reg < lim && idx_reg < SLOTS_X) begin
                    free_we   = 1'b1;
                    free_wval = 1'b0;
                    own_we    = 1'b1;
                    idx_next  = idx_reg + EXT_W'(1);
                end else if (prv_reg[IDX_W-1:0] == NONE_SLOT) begin
                    ffs_next       = clamp_slot(nxt_reg);
                    res_stat_next  = stat_reg;
                    res_setr_next  = setr_reg;
                    res_start_next = cur_reg[IDX_W-1:0];
                    state_next     = S_OUT;
                end else begin
                    idx_next   = prv_reg;
                    state_next = S_RELINK;
                end
            end
            S_RELINK: begin
                if (free_at(free_reg, idx_reg)) begin
                    link_we    = 1'b1;
                    link_wdata = clamp_slot(nxt_reg);
                    idx_next   = idx_reg + EXT_W'(1);
                end else begin
                    res_stat_next  = stat_reg;
                    res_setr_next  = setr_reg;
                    res_start_next = cur_reg[IDX_W-1:0];
                    state_next     = S_OUT;
                end
            end
            S_R_OWN: begin
                res_owner_next = own_rdata;
                res_clr_next   = (rec_reg == {1'b0, fi_reg});
                end_next = {2'b00, fi_reg} + {1'b0, n_reg} - EXT_W'(1);
                if (free_at(free_reg, {2'b00, fi_reg} + {1'b0, n_reg})) begin
                    end_next = {2'b00, fi_reg} + {1'b0, n_reg};
                end
                state_next = S_R_END2;
            end
            S_R_END2: begin
                idx_next = {2'b00, fi_reg};
                if (free_at(free_reg, end_reg + EXT_W'(1))) begin
                    rd_idx_next = end_reg;
                    state_next  = S_R_END3;
                end else begin
                    state_next = S_R_FREE;
                end
            end
            S_R_END3: begin
                end_next   = lk;
                state_next = S_R_FREE;
            end
            S_R_FREE: begin
                if (idx_reg < {2'b00, fi_reg} + {1'b0, n_reg} && idx_reg < SLOTS_X) begin
                    free_we    = 1'b1;
                    free_wval  = 1'b1;
                    link_we    = 1'b1;
                    link_wdata = clamp_slot(end_reg);
                    idx_next   = idx_reg + EXT_W'(1);
                end else begin
                    nxt_next   = {1'b0, ffs_reg};
                    prv_next   = {1'b0, NONE_SLOT};
                    guard_next = '0;
                    state_next = S_R_WALK;
                end
            end
            S_R_WALK: begin
                if (nxt_reg < {2'b00, fi_reg} && guard_reg < IDX_W'(TABLE_SLOTS)) begin
                    guard_next = guard_reg + IDX_W'(1);
                    if (prv_reg[IDX_W-1:0] == NONE_SLOT
                        || !free_at(free_reg, prv_reg + EXT_W'(1))) begin
                        prv_next = nxt_reg;
                    end
                    rd_idx_next = nxt_reg;
                    state_next  = S_R_WNEXT;
                end else begin
                    state_next = S_R_TAIL;
                end
            end
            S_R_WNEXT: begin
                nxt_next   = lk;
                state_next = S_R_WALK;
            end
            S_R_TAIL: begin
                if (end_reg == {2'b00, fi_reg} + {1'b0, n_reg} - EXT_W'(1)
                    && end_reg < SLOTS_X) begin
                    link_we    = 1'b1;
                    link_waddr = end_reg[SLOT_W-1:0];
                    link_wdata = clamp_slot(nxt_reg);
                end
                res_stat_next = STAT_DONE;
                if (prv_reg[IDX_W-1:0] == NONE_SLOT) begin
                    ffs_next   = {1'b0, fi_reg};
                    state_next = S_OUT;
                end else begin
                    idx_next   = prv_reg;
                    state_next = S_R_RELINK;
                end
            end
            S_R_RELINK: begin
                if (idx_reg < {2'b00, fi_reg}) begin
                    link_we    = 1'b1;
                    link_wdata = clamp_slot(end_reg);
                    idx_next   = idx_reg + EXT_W'(1);
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            ffs_reg      <= '0;
            table_id_reg <= 16'hFFFF;
            free_reg     <= '1;
            lvalid_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ffs_reg   <= ffs_next;
            if (cfg_wr_en) begin
                table_id_reg <= cfg_wr_data;
            end
            if (free_we) begin
                free_reg[free_widx] <= free_wval;
            end
            if (link_we) begin
                lvalid_reg[link_waddr] <= 1'b1;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            op_reg       <= s_opcode;
            lib_reg      <= s_lib_id;
            cnt_reg      <= s_got_entries;
            tn_reg       <= s_table_number;
            rec_reg      <= s_recorded_first;
            last_tab_reg <= s_lib_last_table;
            fi_reg       <= s_first_index;
        end
        cur_reg       <= cur_next;
        nxt_reg       <= nxt_next;
        prv_reg       <= prv_next;
        idx_reg       <= idx_next;
        end_reg       <= end_next;
        n_reg         <= n_next;
        guard_reg     <= guard_next;
        stat_reg      <= stat_next;
        setr_reg      <= setr_next;
        rd_idx_reg    <= rd_idx_next;
        res_stat_reg  <= res_stat_next;
        res_setr_reg  <= res_setr_next;
        res_start_reg <= res_start_next;
        res_owner_reg <= res_owner_next;
        res_clr_reg   <= res_clr_next;
        if (state_reg == S_OUT && out_free) begin
            m_status_reg       <= res_stat_reg;
            m_set_record_reg   <= res_setr_reg;
            m_start_index_reg  <= res_start_reg;
            m_owner_lib_reg    <= res_owner_reg;
            m_clear_record_reg <= res_clr_reg;
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_set_record   = m_set_record_reg;
    assign m_start_index  = m_start_index_reg;
    assign m_owner_lib    = m_owner_lib_reg;
    assign m_clear_record = m_clear_record_reg;

endmodule

[src/csa_checker.sv]
// ----------------------------------------------------------------------------
// csa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "contiguous_slot_allocator_defines.svh"

module csa_checker
    import csa_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic        m_set_record,
    input logic [8:0]  m_start_index,
    input logic [15:0] m_owner_lib,
    input logic        m_clear_record
);

    // A stalled result word holds.
    `CSA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_start_index))

    // One word at a time: the block is busy right after an accept.
    `CSA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // An already placed library reports no slot and no record change.
    `CSA_ASSERT_NOW(a_placed_quiet, m_valid && m_status == STAT_PLACED, !m_set_record && m_start_index == NONE_SLOT && !m_clear_record)

    // Only inserts ask to set the record, and inserts report no owner.
    `CSA_ASSERT_NOW(a_insert_fields, m_valid && m_set_record, m_owner_lib == 16'd0 && !m_clear_record)

endmodule

bind contiguous_slot_allocator csa_checker u_csa_checker (.*);

[verif/slot_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_checker
// Watches both channels of the slot allocator, keeps its own copy of the slot
// table, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------

module slot_table_checker
    import csa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_lib_id,
    input  logic [15:0] s_got_entries,
    input  logic [7:0]  s_table_number,
    input  logic [8:0]  s_recorded_first,
    input  logic [15:0] s_lib_last_table,
    input  logic [7:0]  s_first_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic        m_set_record,
    input  logic [8:0]  m_start_index,
    input  logic [15:0] m_owner_lib,
    input  logic        m_clear_record,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic        set_record;
        logic [8:0]  start_index;
        logic [15:0] owner_lib;
        logic        clear_record;
    } slot_result_t;

    slot_result_t result_queue[$];

    logic [15:0] my_table_id;
    bit          free_bit[TABLE_SLOTS];
    int unsigned link_of[TABLE_SLOTS];
    logic [15:0] owner_of[TABLE_SLOTS];
    int unsigned free_head;

    function automatic bit free_at(int unsigned i);
        return i < TABLE_SLOTS && free_bit[i];
    endfunction

    function automatic int unsigned link_rd(int unsigned i);
        if (i >= TABLE_SLOTS || link_of[i] >= TABLE_SLOTS) return TABLE_SLOTS;
        return link_of[i];
    endfunction

    function automatic void link_wr(int unsigned i, int unsigned v);
        if (i < TABLE_SLOTS) link_of[i] = (v >= TABLE_SLOTS) ? TABLE_SLOTS : v;
    endfunction

    function automatic slot_result_t mk(logic [1:0] st, logic sr, int unsigned si,
                                        logic [15:0] own, logic clr);
        slot_result_t r;
        r.status = st;
        r.set_record = sr;
        r.start_index = si[8:0];
        r.owner_lib = own;
        r.clear_record = clr;
        return r;
    endfunction

    function automatic slot_result_t place_page(logic [15:0] lib, int unsigned cnt,
                                                int unsigned tn, int unsigned rec);
        int unsigned start, prev, nxt, n, guard, lk, src, e;
        logic sr;
        logic [1:0] st;
        prev = TABLE_SLOTS;
        nxt = 0;
        if (rec != TABLE_SLOTS) return mk(STAT_PLACED, 1'b0, TABLE_SLOTS, 16'd0, 1'b0);
        if (cnt == 0) cnt = 1;
        if (tn < (cnt - 1) / TABLE_SLOTS) begin
            sr = 1'b0;
            if (!(free_head == 0 && link_rd(0) == TABLE_SLOTS - 1 && free_at(1)))
                return mk(STAT_FAIL, 1'b0, TABLE_SLOTS, 16'd0, 1'b0);
            start = 0;
            nxt = TABLE_SLOTS;
            n = TABLE_SLOTS;
            st = STAT_PARTIAL;
        end else begin
            guard = 0;
            sr = 1'b1;
            st = STAT_DONE;
            n = cnt % TABLE_SLOTS;
            if (n == 0) n = TABLE_SLOTS;
            start = free_head;
            while (free_at(start)) begin
                if (guard >= TABLE_SLOTS) begin
                    start = TABLE_SLOTS;
                    break;
                end
                guard++;
                lk = link_rd(start);
                src = (lk == TABLE_SLOTS) ? 32'hFFFF_FFFF : lk;
                if ((src != 32'hFFFF_FFFF || n == 1) && (src - start + 1) >= n) begin
                    e = start + n - 1;
                    if (link_rd(e) == TABLE_SLOTS || !free_at(e + 1)) nxt = link_rd(e);
                    else nxt = start + n;
                    break;
                end else if (src != 32'hFFFF_FFFF) begin
                    prev = lk;
                    start = link_rd(prev);
                end else begin
                    start = TABLE_SLOTS;
                end
            end
        end
        if (start >= TABLE_SLOTS) return mk(STAT_FAIL, sr, TABLE_SLOTS, 16'd0, 1'b0);
        for (int unsigned i = start; i < start + n && i < TABLE_SLOTS; i++) begin
            free_bit[i] = 0;
            owner_of[i] = lib;
        end
        if (prev == TABLE_SLOTS) begin
            free_head = (nxt >= TABLE_SLOTS) ? TABLE_SLOTS : nxt;
        end else begin
            for (int unsigned i = prev; free_at(i); i++) link_wr(i, nxt);
        end
        return mk(st, sr, start, 16'd0, 1'b0);
    endfunction

    function automatic slot_result_t free_block(int unsigned cnt, int unsigned rec,
                                                logic [15:0] last_tab, int unsigned fi);
        int unsigned n, e, nxt, prev, guard;
        logic [15:0] own;
        bit is_last;
        if (fi >= TABLE_SLOTS || free_bit[fi])
            return mk(STAT_FAIL, 1'b0, TABLE_SLOTS, 16'd0, 1'b0);
        own = owner_of[fi];
        is_last = (my_table_id == last_tab);
        n = cnt;
        if (is_last) n = n % TABLE_SLOTS;
        if (!is_last || n == 0) n = TABLE_SLOTS;
        e = fi + n - 1;
        if (e + 1 < TABLE_SLOTS && free_bit[e + 1]) e++;
        if (e + 1 < TABLE_SLOTS && free_bit[e + 1]) e = link_rd(e);
        for (int unsigned i = fi; i < fi + n && i < TABLE_SLOTS; i++) begin
            free_bit[i] = 1;
            link_wr(i, e);
        end
        nxt = free_head;
        prev = TABLE_SLOTS;
        guard = 0;
        while (nxt < fi && guard < TABLE_SLOTS) begin
            guard++;
            if (prev == TABLE_SLOTS || !free_at(prev + 1)) prev = nxt;
            nxt = link_rd(nxt);
        end
        if (e == fi + n - 1) link_wr(e, nxt);
        if (prev == TABLE_SLOTS) begin
            free_head = fi;
        end else begin
            for (int unsigned i = prev; i < fi; i++) link_wr(i, e);
        end
        return mk(STAT_DONE, 1'b0, TABLE_SLOTS, own, rec == fi);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        slot_result_t want;
        if (!aresetn) begin
            fail_count = 0;
            pending = 0;
            my_table_id <= 16'hFFFF;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                free_bit[i] = 1;
                link_of[i] = TABLE_SLOTS - 1;
                owner_of[i] = 0;
            end
            link_of[TABLE_SLOTS - 1] = TABLE_SLOTS;
            free_head = 0;
        end else begin
            if (cfg_wr_en) my_table_id <= cfg_wr_data;
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    $display("[%0t] result word with nothing expected", $realtime);
                    fail_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_set_record !== want.set_record)
                        report_mismatch("set_record", m_set_record, want.set_record);
                    if (m_start_index !== want.start_index)
                        report_mismatch("start_index", m_start_index, want.start_index);
                    if (m_owner_lib !== want.owner_lib)
                        report_mismatch("owner_lib", m_owner_lib, want.owner_lib);
                    if (m_clear_record !== want.clear_record)
                        report_mismatch("clear_record", m_clear_record, want.clear_record);
                end
            end
            if (s_valid && s_ready) begin
                if (s_opcode == OP_INSERT)
                    result_queue.push_back(place_page(s_lib_id, s_got_entries,
                                                      s_table_number, s_recorded_first));
                else
                    result_queue.push_back(free_block(s_got_entries, s_recorded_first,
                                                      s_lib_last_table, s_first_index));
            end
            pending = result_queue.size();
        end
    end

endmodule

[verif/contiguous_slot_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_slot_allocator_tb
// Drives insert and remove words into the slot allocator, mostly well-formed
// library load and unload sequences, and lets the checker judge every result.
// ----------------------------------------------------------------------------

module contiguous_slot_allocator_tb;
    import csa_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic [15:0] s_lib_id;
    logic [15:0] s_got_entries;
    logic [7:0]  s_table_number;
    logic [8:0]  s_recorded_first;
    logic [15:0] s_lib_last_table;
    logic [7:0]  s_first_index;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic        m_set_record;
    logic [8:0]  m_start_index;
    logic [15:0] m_owner_lib;
    logic        m_clear_record;
    int          fail_count;
    int          pending;

    // Idle percentage for each side; zero during the calm stretch.
    int          idle_pct;

    // First slots of libraries that the stimulus believes are loaded.
    int          loaded_first[$];

    contiguous_slot_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_lib_id(s_lib_id), .s_got_entries(s_got_entries),
        .s_table_number(s_table_number), .s_recorded_first(s_recorded_first),
        .s_lib_last_table(s_lib_last_table), .s_first_index(s_first_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_set_record(m_set_record), .m_start_index(m_start_index),
        .m_owner_lib(m_owner_lib), .m_clear_record(m_clear_record)
    );

    slot_table_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_lib_id(s_lib_id), .s_got_entries(s_got_entries),
        .s_table_number(s_table_number), .s_recorded_first(s_recorded_first),
        .s_lib_last_table(s_lib_last_table), .s_first_index(s_first_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_set_record(m_set_record), .m_start_index(m_start_index),
        .m_owner_lib(m_owner_lib), .m_clear_record(m_clear_record),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // The result side stalls at random on each falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Presents one word and holds it until the block takes it. The word goes
    // out on a later falling edge than the one that dropped the previous
    // word, after a random idle gap, so gaps land at every phase of the work.
    task automatic send_word(logic op, logic [15:0] lib, logic [15:0] cnt, logic [7:0] tn,
                             logic [8:0] rec, logic [15:0] last_tab, logic [7:0] fi);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) @(negedge aclk);
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_lib_id         <= lib;
        s_got_entries    <= cnt;
        s_table_number   <= tn;
        s_recorded_first <= rec;
        s_lib_last_table <= last_tab;
        s_first_index    <= fi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Waits for every expected result, then lets the block finish any work
    // whose result is not tracked, before a register write.
    task automatic wait_idle_and_config(logic [15:0] id);
        while (pending != 0) @(negedge aclk);
        repeat (1200) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    logic [15:0] my_id;

    // Tracks where each insert landed, so removes can target real blocks.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && m_start_index < TABLE_SLOTS &&
            m_status == STAT_DONE && m_set_record) begin
            loaded_first.push_back(m_start_index);
        end
    end

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int k, sz, fi;
        logic [15:0] cnt;
        idle_pct         = 29;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 16'd0;
        s_valid          = 1'b0;
        s_opcode         = OP_INSERT;
        s_lib_id         = 16'd0;
        s_got_entries    = 16'd1;
        s_table_number   = 8'd0;
        s_recorded_first = 9'(TABLE_SLOTS);
        s_lib_last_table = 16'd0;
        s_first_index    = 8'd0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        my_id = 16'h0005;
        wait_idle_and_config(my_id);

        // Directed: whole-table partial page, already placed, remove past
        // a free slot, zero count, and the extremes of each field.
        send_word(OP_INSERT, 16'hFFFF, 16'd600, 8'd0, 9'(TABLE_SLOTS), 16'd0, 8'd0);
        send_word(OP_INSERT, 16'h0001, 16'd600, 8'd1, 9'(TABLE_SLOTS), 16'd0, 8'd0);
        send_word(OP_INSERT, 16'h0002, 16'd3, 8'd0, 9'd7, 16'd0, 8'd0);
        send_word(OP_REMOVE, 16'h0000, 16'd600, 8'd0, 9'd0, 16'h1234, 8'd0);
        send_word(OP_REMOVE, 16'h0000, 16'd1, 8'd0, 9'd0, my_id, 8'd0);
        send_word(OP_INSERT, 16'h0003, 16'd0, 8'd255, 9'(TABLE_SLOTS), 16'd0, 8'd0);
        send_word(OP_INSERT, 16'h0004, 16'd256, 8'd0, 9'(TABLE_SLOTS), 16'd0, 8'd0);
        send_word(OP_INSERT, 16'h0005, 16'hFFFF, 8'd255, 9'(TABLE_SLOTS), 16'd0, 8'd0);
        send_word(OP_INSERT, 16'h0006, 16'd5, 8'd0, 9'(TABLE_SLOTS), 16'd0, 8'd0);
        send_word(OP_REMOVE, 16'h0000, 16'hFFFF, 8'd255, 9'd0, my_id, 8'd255);
        send_word(OP_REMOVE, 16'h0000, 16'd5, 8'd1, 9'd1, my_id, 8'd1);
        send_word(OP_REMOVE, 16'h0000, 16'd256, 8'd1, 9'(TABLE_SLOTS), 16'hFFFF, 8'd0);
        send_word(OP_INSERT, 16'h5555, 16'd255, 8'd0, 9'(TABLE_SLOTS), 16'd0, 8'd0);
        send_word(OP_INSERT, 16'hAAAA, 16'd2, 8'd0, 9'(TABLE_SLOTS), 16'd0, 8'd0);
        send_word(OP_REMOVE, 16'h0000, 16'd255, 8'd0, 9'd0, my_id, 8'd0);

        for (int phase = 0; phase < 4; phase++) begin
            // Register settings include both extremes.
            case (phase)
                0: my_id = 16'hFFFF;
                1: my_id = 16'h0000;
                2: my_id = 16'($urandom);
                default: my_id = 16'h00A5;
            endcase
            wait_idle_and_config(my_id);
            loaded_first.delete();
            idle_pct = (phase == 2) ? 0 : 29;
            for (k = 0; k < 112; k++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        // Mostly small libraries so the table fills in many runs.
                        sz = ($urandom_range(9) == 0) ? $urandom_range(1, 255) :
                                                       $urandom_range(1, 12);
                        cnt = ($urandom_range(7) == 0) ? 16'($urandom) : 16'(sz);
                        send_word(OP_INSERT, 16'($urandom), cnt, 8'($urandom_range(3)),
                                  9'(TABLE_SLOTS), 16'($urandom), 8'($urandom));
                    end
                    4, 5, 6, 7: begin
                        // Remove a block at a recorded start slot, or at a random slot if none.
                        fi = (loaded_first.size() != 0) ?
                             loaded_first[$urandom_range(loaded_first.size() - 1)] :
                             $urandom_range(255);
                        sz = $urandom_range(1, 12);
                        send_word(OP_REMOVE, 16'($urandom), 16'(sz),
                                  8'($urandom),
                                  ($urandom_range(1) ? 9'(fi) : 9'($urandom_range(256))),
                                  ($urandom_range(3) != 0) ? my_id : 16'($urandom),
                                  8'(fi));
                    end
                    default: begin
                        // Noise: any field value at all.
                        send_word(1'($urandom), 16'($urandom), 16'($urandom),
                                  8'($urandom), 9'($urandom_range(256)),
                                  16'($urandom), 8'($urandom));
                    end
                endcase
            end
        end

        while (pending != 0) @(negedge aclk);
        repeat (1200) @(negedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/csa_pkg.sv
src/csa_ram.sv
src/contiguous_slot_allocator.sv
src/csa_checker.sv
verif/slot_table_checker.sv
verif/contiguous_slot_allocator_tb.sv
